>>> sv/bpc_pkg.sv
package bpc_pkg;

  localparam int DivW    = 32;
  localparam int SideW   = 64;
  localparam int CfgIdxW = 3;

  localparam logic signed [31:0] B6Offset  = 32'sd4000;
  localparam logic signed [31:0] TRound    = 32'sd8;
  localparam logic signed [31:0] B4Offset  = 32'sd32768;
  localparam logic        [16:0] PScale    = 17'd50000;
  localparam logic signed [12:0] P1Coef    = 13'sd3038;
  localparam logic signed [15:0] P2Coef    = -16'sd7357;
  localparam logic signed [31:0] P3Coef    = 32'sd3791;
  localparam logic signed [31:0] TempMax   = 32'sd32767;
  localparam logic signed [31:0] TempMin   = -32'sd32768;
  localparam logic signed [31:0] PressMax  = 32'sd262143;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ABSENT   = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
    logic        sensor_present;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic        [17:0] pressure_pa;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic        [15:0] raw_pressure;
    logic               neg;
    status_e            status;
  } div1_side_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               hi;
    status_e            status;
  } div2_side_t;

endpackage

>>> sv/bpc_div.sv
module bpc_div
  import bpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DivW-1:0]  quotient_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [0:DivW];
  logic [DivW-1:0]  rem_q  [0:DivW];
  logic [DivW-1:0]  dvd_q  [0:DivW];
  logic [DivW-1:0]  dsr_q  [0:DivW];
  logic [DivW-1:0]  quo_q  [0:DivW];
  logic [SideW-1:0] side_q [0:DivW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      dvd_q[0]  <= dividend_i;
      dsr_q[0]  <= divisor_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 0; g < DivW; g++) begin : g_step
    logic [DivW:0]   trial;
    logic [DivW+1:0] diff;
    logic [DivW-1:0] quo_d;

    always_comb begin
      trial = {rem_q[g], dvd_q[g][DivW-1-g]};
      diff  = {1'b0, trial} - {2'b00, dsr_q[g]};
      quo_d = quo_q[g];
      quo_d[DivW-1-g] = ~diff[DivW+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= diff[DivW+1] ? trial[DivW-1:0] : diff[DivW-1:0];
        dvd_q[g+1]  <= dvd_q[g];
        dsr_q[g+1]  <= dsr_q[g];
        quo_q[g+1]  <= quo_d;
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o    = vld_q[DivW];
  assign quotient_o = quo_q[DivW];
  assign side_o     = side_q[DivW];

endmodule

>>> sv/bpc_temp_front.sv
module bpc_temp_front
  import bpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  in_item_t        item_i,
  input  cal_t            cal_i,
  output logic            valid_o,
  output logic [DivW-1:0] dividend_o,
  output logic [DivW-1:0] divisor_o,
  output div1_side_t      side_o
);

  logic               v1_q, v2_q, v3_q;
  in_item_t           item1_q, item2_q, item3_q;
  logic signed [16:0] diff1_d, diff1_q;
  logic signed [33:0] prod2_full;
  logic signed [31:0] prod2_q;
  logic signed [31:0] x1_d, x1_q;
  logic signed [31:0] den_d, den_q;
  logic signed [16:0] mc_ext;
  logic        [16:0] mc_mag;

  always_comb begin
    diff1_d    = $signed({1'b0, item_i.raw_temperature}) - $signed({1'b0, cal_i.ac6});
    prod2_full = diff1_q * $signed({1'b0, cal_i.ac5});
    x1_d       = prod2_q >>> 15;
    den_d      = x1_d + {{16{cal_i.md[15]}}, cal_i.md};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q <= item_i;
      diff1_q <= diff1_d;
      item2_q <= item1_q;
      prod2_q <= prod2_full[31:0];
      item3_q <= item2_q;
      x1_q    <= x1_d;
      den_q   <= den_d;
    end
  end

  always_comb begin
    mc_ext     = {cal_i.mc[15], cal_i.mc};
    mc_mag     = mc_ext[16] ? -mc_ext : mc_ext;
    dividend_o = {4'b0000, mc_mag, 11'b0};
    divisor_o  = den_q[31] ? 32'(-den_q) : 32'(den_q);
    valid_o    = v3_q;
    side_o.x1           = x1_q;
    side_o.raw_pressure = item3_q.raw_pressure;
    side_o.neg          = cal_i.mc[15] ^ den_q[31];
    if (!item3_q.sensor_present) begin
      side_o.status = STATUS_ABSENT;
    end else if (den_q == '0) begin
      side_o.status = STATUS_DIV_ZERO;
    end else begin
      side_o.status = STATUS_OK;
    end
  end

endmodule

>>> sv/bpc_press_coef.sv
module bpc_press_coef
  import bpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DivW-1:0] quotient_i,
  input  div1_side_t      side_i,
  input  cal_t            cal_i,
  output logic            valid_o,
  output logic [DivW-1:0] dividend_o,
  output logic [DivW-1:0] divisor_o,
  output div2_side_t      side_o
);

  logic               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  status_e            st1_q, st2_q, st3_q, st4_q, st5_q, st6_q, st7_q;
  logic        [15:0] up1_q, up2_q, up3_q, up4_q, up5_q, up6_q;
  logic signed [15:0] t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;

  logic signed [31:0] x2q, b5_d, b5_q;
  logic signed [31:0] tr, b6_d, b6_q;
  logic signed [15:0] t_d;
  logic signed [63:0] m1_full;
  logic signed [47:0] m2_full, m3_full, m4_full, m5_full;
  logic signed [31:0] m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [31:0] sq_q, x2a4_q, x1c4_q, x2a5_q, x1c5_q;
  logic signed [31:0] x3, vsum, b3_q, xp_d, xp_q;
  logic signed [32:0] v33, vsh;
  logic        [31:0] xq, dif;
  logic        [47:0] m6_full;
  logic        [48:0] m7_full;
  logic        [16:0] b4_q;
  logic        [31:0] b7_q;

  always_comb begin
    x2q  = side_i.neg ? -$signed(quotient_i) : $signed(quotient_i);
    b5_d = side_i.x1 + x2q;
    tr   = (b5_q + TRound) >>> 4;
    if (tr > TempMax) begin
      t_d = 16'sh7fff;
    end else if (tr < TempMin) begin
      t_d = -16'sh8000;
    end else begin
      t_d = tr[15:0];
    end
    b6_d    = b5_q - B6Offset;
    m1_full = b6_q * b6_q;
    m2_full = b6_q * cal_i.ac2;
    m3_full = b6_q * cal_i.ac3;
    m4_full = sq_q * cal_i.b2;
    m5_full = sq_q * cal_i.b1;
    x3      = (m4_q >>> 11) + x2a5_q;
    vsum    = {{14{cal_i.ac1[15]}}, cal_i.ac1, 2'b00} + x3 + 32'sd2;
    v33     = {vsum[31], vsum} + (vsum[31] ? 33'sd3 : 33'sd0);
    vsh     = v33 >>> 2;
    xp_d    = ((m5_q >>> 16) + x1c5_q + 32'sd2) >>> 2;
    xq      = 32'(xp_q + B4Offset);
    m6_full = cal_i.ac4 * xq;
    dif     = {16'b0, up6_q} - b3_q;
    m7_full = dif * PScale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q  <= side_i.status;
      up1_q  <= side_i.raw_pressure;
      b5_q   <= b5_d;

      st2_q  <= st1_q;
      up2_q  <= up1_q;
      t2_q   <= t_d;
      b6_q   <= b6_d;

      st3_q  <= st2_q;
      up3_q  <= up2_q;
      t3_q   <= t2_q;
      m1_q   <= m1_full[31:0];
      m2_q   <= m2_full[31:0];
      m3_q   <= m3_full[31:0];

      st4_q  <= st3_q;
      up4_q  <= up3_q;
      t4_q   <= t3_q;
      sq_q   <= m1_q >>> 12;
      x2a4_q <= m2_q >>> 11;
      x1c4_q <= m3_q >>> 13;

      st5_q  <= st4_q;
      up5_q  <= up4_q;
      t5_q   <= t4_q;
      m4_q   <= m4_full[31:0];
      m5_q   <= m5_full[31:0];
      x2a5_q <= x2a4_q;
      x1c5_q <= x1c4_q;

      st6_q  <= st5_q;
      up6_q  <= up5_q;
      t6_q   <= t5_q;
      b3_q   <= vsh[31:0];
      xp_q   <= xp_d;

      st7_q  <= st6_q;
      t7_q   <= t6_q;
      b4_q   <= m6_full[31:15];
      b7_q   <= m7_full[31:0];
    end
  end

  always_comb begin
    valid_o     = v7_q;
    dividend_o  = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
    divisor_o   = {15'b0, b4_q};
    side_o.temp = t7_q;
    side_o.hi   = b7_q[31];
    if (st7_q == STATUS_OK && b4_q == '0) begin
      side_o.status = STATUS_DIV_ZERO;
    end else begin
      side_o.status = st7_q;
    end
  end

endmodule

>>> sv/bpc_press_final.sv
module bpc_press_final
  import bpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DivW-1:0] quotient_i,
  input  div2_side_t      side_i,
  output logic            valid_o,
  output out_item_t       item_o
);

  logic               v1_q, v2_q, v3_q;
  div2_side_t         sd1_q, sd2_q, sd3_q;
  logic signed [31:0] p1_q, p2_q, p3_q;
  logic signed [23:0] s;
  logic signed [47:0] m7_full, m8_full;
  logic signed [44:0] m9_full;
  logic signed [31:0] m7_q, m8_q, m9_q, x2_q;
  logic signed [31:0] pr;

  always_comb begin
    s       = 24'(p1_q >>> 8);
    m7_full = s * s;
    m8_full = p1_q * P2Coef;
    m9_full = m7_q * P1Coef;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd1_q <= side_i;
      p1_q  <= side_i.hi ? $signed({quotient_i[30:0], 1'b0}) : $signed(quotient_i);
      sd2_q <= sd1_q;
      p2_q  <= p1_q;
      m7_q  <= m7_full[31:0];
      m8_q  <= m8_full[31:0];
      sd3_q <= sd2_q;
      p3_q  <= p2_q;
      m9_q  <= m9_full[31:0];
      x2_q  <= m8_q >>> 16;
    end
  end

  always_comb begin
    pr      = p3_q + (((m9_q >>> 16) + x2_q + P3Coef) >>> 4);
    valid_o = v3_q;
    item_o.status = sd3_q.status;
    if (sd3_q.status != STATUS_OK) begin
      item_o.temperature_tenths = '0;
      item_o.pressure_pa        = '0;
    end else begin
      item_o.temperature_tenths = sd3_q.temp;
      if (pr < 0) begin
        item_o.pressure_pa = '0;
      end else if (pr > PressMax) begin
        item_o.pressure_pa = '1;
      end else begin
        item_o.pressure_pa = pr[17:0];
      end
    end
  end

endmodule

>>> sv/barometric_pressure_compensation.sv
// Barometric pressure compensation, oversampling setting zero. Each item carries one raw
// temperature word, one raw pressure word and a sensor-present flag; the block returns
// temperature in tenths of a degree, pressure in pascals and a status (ok, sensor absent,
// zero divisor). An item is accepted every cycle while the output is not stalled; the
// path runs through two 33-stage restoring dividers, one input stage and one quotient
// bit per stage, for the temperature and the pressure quotients, plus the 13 multiplier
// stages around them and the output register. A stalled output freezes the whole
// pipeline. Load the five calibration words while the pipeline is empty.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  cal_t        cal;
  logic        en;

  logic            fr_valid;
  logic [DivW-1:0] fr_dividend, fr_divisor;
  div1_side_t      fr_side;
  logic            d1_valid;
  logic [DivW-1:0] d1_quot;
  logic [SideW-1:0] d1_side;

  logic            pc_valid;
  logic [DivW-1:0] pc_dividend, pc_divisor;
  div2_side_t      pc_side;
  logic            d2_valid;
  logic [DivW-1:0] d2_quot;
  logic [SideW-1:0] d2_side;

  logic      fin_valid;
  out_item_t fin_item;
  logic      out_valid_q;
  out_item_t out_item_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_AC1_AC2: ac12_q <= cfg_data_i;
        CFG_AC3_AC4: ac34_q <= cfg_data_i;
        CFG_AC5_AC6: ac56_q <= cfg_data_i;
        CFG_B1_B2:   b12_q  <= cfg_data_i;
        CFG_MC_MD:   mcmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = ac12_q[31:16];
    cal.ac2 = ac12_q[15:0];
    cal.ac3 = ac34_q[31:16];
    cal.ac4 = ac34_q[15:0];
    cal.ac5 = ac56_q[31:16];
    cal.ac6 = ac56_q[15:0];
    cal.b1  = b12_q[31:16];
    cal.b2  = b12_q[15:0];
    cal.mc  = mcmd_q[31:16];
    cal.md  = mcmd_q[15:0];
  end

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  bpc_temp_front u_front (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (in_valid_i),
    .item_i     (in_item_i),
    .cal_i      (cal),
    .valid_o    (fr_valid),
    .dividend_o (fr_dividend),
    .divisor_o  (fr_divisor),
    .side_o     (fr_side)
  );

  bpc_div u_div_temp (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (fr_valid),
    .dividend_i (fr_dividend),
    .divisor_i  (fr_divisor),
    .side_i     (SideW'(fr_side)),
    .valid_o    (d1_valid),
    .quotient_o (d1_quot),
    .side_o     (d1_side)
  );

  bpc_press_coef u_coef (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (d1_valid),
    .quotient_i (d1_quot),
    .side_i     (div1_side_t'(d1_side[$bits(div1_side_t)-1:0])),
    .cal_i      (cal),
    .valid_o    (pc_valid),
    .dividend_o (pc_dividend),
    .divisor_o  (pc_divisor),
    .side_o     (pc_side)
  );

  bpc_div u_div_press (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (pc_valid),
    .dividend_i (pc_dividend),
    .divisor_i  (pc_divisor),
    .side_i     (SideW'(pc_side)),
    .valid_o    (d2_valid),
    .quotient_o (d2_quot),
    .side_o     (d2_side)
  );

  bpc_press_final u_final (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (d2_valid),
    .quotient_i (d2_quot),
    .side_i     (div2_side_t'(d2_side[$bits(div2_side_t)-1:0])),
    .valid_o    (fin_valid),
    .item_o     (fin_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_item_q <= fin_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> bench/barometric_pressure_compensation_tb.sv
module barometric_pressure_compensation_tb;
  import bpc_pkg::*;

  localparam int HoldLimit = 4000;
  localparam int DrainCycles = 60;
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] cal_word [5];
  out_item_t pending_results [$];
  int errors;
  int items_sent;
  int results_seen;
  int idle_pct;
  int hold_count;
  int quiet_cycles;

  barometric_pressure_compensation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t compensate(in_item_t it);
    out_item_t r;
    int ut, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    int x1, x2, x3, den, b5, b6, sq, b3, p, t, pr;
    longint num;
    bit [31:0] ac4, u, prod, b4, b7, pu;
    bit [63:0] wide;
    r.temperature_tenths = '0;
    r.pressure_pa = '0;
    r.status = STATUS_ABSENT;
    if (!it.sensor_present) begin
      return r;
    end
    ut = it.raw_temperature;
    ac1 = $signed(cal_word[0][31:16]);
    ac2 = $signed(cal_word[0][15:0]);
    ac3 = $signed(cal_word[1][31:16]);
    ac4 = cal_word[1][15:0];
    ac5 = cal_word[2][31:16];
    ac6 = cal_word[2][15:0];
    b1 = $signed(cal_word[3][31:16]);
    b2 = $signed(cal_word[3][15:0]);
    mc = $signed(cal_word[4][31:16]);
    md = $signed(cal_word[4][15:0]);
    r.status = STATUS_DIV_ZERO;
    x1 = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) begin
      return r;
    end
    num = mc * 2048;
    x2 = int'(num / longint'(den));
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3 + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    u = x3 + 32768;
    prod = ac4 * u;
    b4 = prod >> 15;
    if (b4 == 0) begin
      return r;
    end
    b7 = (32'(it.raw_pressure) - 32'(b3)) * 32'd50000;
    if (b7 < 32'h8000_0000) begin
      wide = ({32'b0, b7} * 64'd2) / {32'b0, b4};
      pu = wide[31:0];
    end else begin
      pu = (b7 / b4) * 32'd2;
    end
    p = signed'(pu);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    pr = p + ((x1 + x2 + 3791) >>> 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (pr < 0) pr = 0;
    if (pr > 262143) pr = 262143;
    r.temperature_tenths = t[15:0];
    r.pressure_pa = pr[17:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  task automatic report(string field, int got, int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d, expected %0d", results_seen, field, got,
             want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        pending_results.push_back(compensate(in_item));
        quiet_cycles = 0;
      end
      if (cfg_valid && cfg_ready) quiet_cycles = 0;
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          errors++;
          $display("unexpected result %0d", results_seen);
        end else begin
          want = pending_results.pop_front();
          if (out_item.temperature_tenths !== want.temperature_tenths)
            report("temperature", out_item.temperature_tenths, want.temperature_tenths);
          if (out_item.pressure_pa !== want.pressure_pa)
            report("pressure", out_item.pressure_pa, want.pressure_pa);
          if (out_item.status !== want.status)
            report("status", out_item.status, want.status);
        end
        results_seen++;
      end
      if (quiet_cycles >= HoldLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_item(logic [15:0] ut, logic [15:0] up, logic present);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{raw_temperature: ut, raw_pressure: up, sensor_present: present};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_MC_MD) cal_word[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cal(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                          logic [31:0] w3, logic [31:0] w4);
    wait_drained();
    write_reg(CFG_AC1_AC2, w0);
    write_reg(CFG_AC3_AC4, w1);
    write_reg(CFG_AC5_AC6, w2);
    write_reg(CFG_B1_B2, w3);
    write_reg(CFG_MC_MD, w4);
  endtask

  task automatic load_typical();
    load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
  endtask

  task automatic send_corners();
    send_item(16'h0000, 16'h0000, 1'b1);
    send_item(16'hffff, 16'hffff, 1'b1);
    send_item(16'hffff, 16'h0000, 1'b1);
    send_item(16'h0000, 16'hffff, 1'b1);
    send_item(16'd27898, 16'd23843, 1'b1);
    send_item(16'd27898, 16'd23843, 1'b0);
  endtask

  task automatic test_reset_calibration();
    send_corners();
  endtask

  task automatic test_directed();
    load_typical();
    send_corners();
    send_item(16'h8000, 16'h7fff, 1'b1);
    load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
             {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
    send_item(16'd27898, 16'd23843, 1'b1);
    load_cal('0, '0, {16'd0, 16'd23153}, '0, {-16'sd8711, 16'sd0});
    send_item(16'd27898, 16'd23843, 1'b1);
    wait_drained();
    write_reg(CfgUnusedLo, 32'hffff_ffff);
    write_reg(CfgUnusedHi, 32'h1234_5678);
    send_item(16'd100, 16'd200, 1'b1);
  endtask

  task automatic test_extreme_calibration();
    load_cal('1, '1, '1, '1, '1);
    send_corners();
    load_cal(32'h8000_8000, 32'h8000_ffff, 32'hffff_ffff, 32'h8000_8000, 32'h8000_8000);
    send_corners();
    load_cal(32'h7fff_7fff, 32'h7fff_ffff, 32'hffff_0000, 32'h7fff_7fff, 32'h7fff_7fff);
    send_corners();
  endtask

  task automatic test_random(int count, bit typical);
    int i;
    if (typical)
      load_cal({16'(408 + $urandom_range(400) - 200), 16'(-72 + $urandom_range(200) - 100)},
               {16'(-14383 + $urandom_range(2000) - 1000), 16'(32741 - $urandom_range(4000))},
               {16'(32757 - $urandom_range(8000)), 16'(23153 + $urandom_range(4000) - 2000)},
               {16'(6190 + $urandom_range(1000) - 500), 16'($urandom_range(20))},
               {16'(-8711 + $urandom_range(2000) - 1000), 16'(2868 + $urandom_range(600))});
    else
      load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_item(16'($urandom), 16'($urandom), $urandom_range(9) != 0);
      else
        send_item(16'(20000 + $urandom_range(15000)), 16'(15000 + $urandom_range(20000)),
                  $urandom_range(9) != 0);
    end
  endtask

  task automatic test_backpressure();
    int i;
    load_typical();
    idle_pct = 0;
    @(negedge clk);
    hold_count = 300;
    for (i = 0; i < 120; i++) send_item(16'($urandom), 16'($urandom), 1'b1);
    wait_drained();
    idle_pct = 37;
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    idle_pct = 37;
    hold_count = 0;
    quiet_cycles = 0;
    for (int k = 0; k < 5; k++) cal_word[k] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_calibration();
    test_directed();
    test_extreme_calibration();
    test_random(100, 1'b1);
    test_random(60, 1'b0);
    idle_pct = 0;
    test_random(80, 1'b1);
    idle_pct = 37;
    test_backpressure();
    test_random(50, 1'b1);
    test_random(60, 1'b0);
    test_random(50, 1'b1);
    wait_drained();
    $display("covered %0d items and %0d results over reset, directed, extreme and random",
             items_sent, results_seen);
    $display("calibration sets, including output hold-off and drained pauses");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> barometric_pressure_compensation.f
sv/bpc_pkg.sv
sv/bpc_div.sv
sv/bpc_temp_front.sv
sv/bpc_press_coef.sv
sv/bpc_press_final.sv
sv/barometric_pressure_compensation.sv
bench/barometric_pressure_compensation_tb.sv
